// ===== rtl/fbpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, widths and defaults of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int MAX_BLOCKS_DEF        = 256;
  localparam int WORD_BYTES_DEF        = 8;
  localparam int POOL_HEADER_BYTES_DEF = 24;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int OFFSET_W  = 20;
  localparam int COUNT_W   = 9;
  localparam int BCOUNT_W  = 9;
  localparam int PAYLOAD_W = 13;
  localparam int CFG_IDX_W = 1;

  localparam int OFFSET_MAX = 1048575;

  localparam logic [BCOUNT_W-1:0]  BCOUNT_RST  = 9'd256;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_RST = 13'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_COUNT   = 1'b0,
    REG_PAYLOAD_BYTES = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_FIN
  } state_e;

  // configuration as seen by the controller
  typedef struct packed {
    logic [BCOUNT_W-1:0]  block_count;
    logic [PAYLOAD_W-1:0] pay_words;   // payload size in words, rounded up
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/fixed_block_pool_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block pool with a free list held in a single-port-read link memory.
// ----------------------------------------------------------------------------
// sequence: allocate, free and unknown commands are taken in S_IDLE and give their
//   result from S_FIN, which waits out an output stall; initialize first runs S_INIT
//   (one link write per block); in_stall_o holds off new ones until S_IDLE again
// reset: the free list is empty and every free is invalid until the first initialize;
//   the link memory is not cleared, so the block is ready right after reset
module fixed_block_pool_allocator_top #(
  parameter int MAX_BLOCKS        = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BYTES        = fbpa_pkg::WORD_BYTES_DEF,
  parameter int POOL_HEADER_BYTES = fbpa_pkg::POOL_HEADER_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [fbpa_pkg::PAYLOAD_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [fbpa_pkg::CMD_W-1:0]     command_i,
  input  wire logic [fbpa_pkg::IDX_W-1:0]     block_index_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [fbpa_pkg::STATUS_W-1:0]       status_o,
  output logic [fbpa_pkg::IDX_W-1:0]          granted_index_o,
  output logic [fbpa_pkg::OFFSET_W-1:0]       payload_offset_o,
  output logic [fbpa_pkg::COUNT_W-1:0]        free_count_o
);
  import fbpa_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);

  cfg_t          cfg;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [LW:0]   mem_rdata;

  fbpa_cfg #(
    .WORD_BYTES (WORD_BYTES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fbpa_link_mem #(
    .DEPTH (MAX_BLOCKS),
    .AW    (AW),
    .DW    (LW + 1)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fbpa_ctrl #(
    .MAX_BLOCKS        (MAX_BLOCKS),
    .WORD_BYTES        (WORD_BYTES),
    .POOL_HEADER_BYTES (POOL_HEADER_BYTES),
    .AW                (AW),
    .LW                (LW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .block_index_i    (block_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_index_o  (granted_index_o),
    .payload_offset_o (payload_offset_o),
    .free_count_o     (free_count_o),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/fbpa_link_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_link_mem
// Link memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_link_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/fbpa_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_cfg
// Configuration registers; payload size is kept as a rounded word count.
// ----------------------------------------------------------------------------
module fbpa_cfg #(
  parameter int WORD_BYTES = fbpa_pkg::WORD_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fbpa_pkg::PAYLOAD_W-1:0]  cfg_data_i,
  output fbpa_pkg::cfg_t                       cfg_o
);
  import fbpa_pkg::*;

  // floor(x / WORD_BYTES) as x * RECIP >> SHIFT, exact for x below 2**14
  localparam int SHIFT = 18;
  localparam int RECIP = ((1 << SHIFT) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int XW    = PAYLOAD_W + 1;
  localparam logic [PAYLOAD_W-1:0] WORDS_RST =
    PAYLOAD_W'((64 + WORD_BYTES - 1) / WORD_BYTES);

  logic [BCOUNT_W-1:0]  block_count_q;
  logic [PAYLOAD_W-1:0] pay_words_q, pay_words_d;
  logic [XW-1:0]        round_up;
  logic [31:0]          recip_prod;

  always_comb begin
    round_up    = XW'(cfg_data_i) + XW'(WORD_BYTES - 1);
    recip_prod  = 32'(round_up) * 32'(RECIP);
    pay_words_d = PAYLOAD_W'(recip_prod >> SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BCOUNT_RST;
      pay_words_q   <= WORDS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BLOCK_COUNT:   block_count_q <= cfg_data_i[BCOUNT_W-1:0];
        REG_PAYLOAD_BYTES: pay_words_q   <= pay_words_d;
        default: ;
      endcase
    end
  end

  assign cfg_o.block_count = block_count_q;
  assign cfg_o.pay_words   = pay_words_q;

endmodule
`default_nettype wire

// ===== rtl/fbpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Command sequencer: head and free count, link memory access, result register.
// ----------------------------------------------------------------------------
module fbpa_ctrl #(
  parameter int MAX_BLOCKS        = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BYTES        = fbpa_pkg::WORD_BYTES_DEF,
  parameter int POOL_HEADER_BYTES = fbpa_pkg::POOL_HEADER_BYTES_DEF,
  parameter int AW                = $clog2(MAX_BLOCKS),
  parameter int LW                = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire fbpa_pkg::cfg_t                 cfg_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [fbpa_pkg::CMD_W-1:0]     command_i,
  input  wire logic [fbpa_pkg::IDX_W-1:0]     block_index_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [fbpa_pkg::STATUS_W-1:0]       status_o,
  output logic [fbpa_pkg::IDX_W-1:0]          granted_index_o,
  output logic [fbpa_pkg::OFFSET_W-1:0]       payload_offset_o,
  output logic [fbpa_pkg::COUNT_W-1:0]        free_count_o,
  output logic                                mem_we_o,
  output logic [AW-1:0]                       mem_waddr_o,
  output logic [LW:0]                         mem_wdata_o,
  output logic                                mem_re_o,
  output logic [AW-1:0]                       mem_raddr_o,
  input  wire logic [LW:0]                    mem_rdata_i
);
  import fbpa_pkg::*;

  localparam logic [LW-1:0] MARK = LW'(MAX_BLOCKS);
  localparam int PW = AW + PAYLOAD_W;
  localparam int FW = (PW + 4 > OFFSET_W + 1) ? PW + 4 : OFFSET_W + 1;

  state_e               state_q, state_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic                 bad_q, bad_d;
  logic                 empty_q, empty_d;
  logic [LW-1:0]        head_q, head_d;
  logic [LW-1:0]        cnt_q, cnt_d;
  logic                 inited_q, inited_d;
  logic [AW-1:0]        sweep_q, sweep_d;
  logic [PW-1:0]        prod_q, prod_d;

  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [IDX_W-1:0]     granted_q, granted_d;
  logic [OFFSET_W-1:0]  offset_q, offset_d;
  logic [COUNT_W-1:0]   count_q, count_d;

  logic                 out_free;
  logic [LW-1:0]        pool_n;
  logic [LW-1:0]        sweep_next;
  logic [FW-1:0]        offset_full;

  always_comb begin
    if (cfg_i.block_count == '0) begin
      pool_n = LW'(1);
    end else if (32'(cfg_i.block_count) > MAX_BLOCKS) begin
      pool_n = MARK;
    end else begin
      pool_n = LW'(cfg_i.block_count);
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign sweep_next  = LW'(sweep_q) + LW'(1);
  assign offset_full = FW'(prod_q) * FW'(WORD_BYTES) + FW'(POOL_HEADER_BYTES + WORD_BYTES);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    bad_d       = bad_q;
    empty_d     = empty_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    inited_d    = inited_q;
    sweep_d     = sweep_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    granted_d   = granted_q;
    offset_d    = offset_q;
    count_d     = count_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = {1'b0, head_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = AW'(block_index_i);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          idx_d   = AW'(block_index_i);
          bad_d   = (32'(block_index_i) >= MAX_BLOCKS) || !inited_q;
          empty_d = (head_q == MARK);
          prod_d  = PW'(head_q[AW-1:0]) * PW'(cfg_i.pay_words + PAYLOAD_W'(1));
          if (command_i == CMD_ALLOC) begin
            mem_re_o    = (head_q != MARK);
            mem_raddr_o = head_q[AW-1:0];
          end else if (command_i == CMD_FREE) begin
            mem_re_o    = 1'b1;
          end
          if (command_i == CMD_INIT) begin
            sweep_d = '0;
            state_d = S_INIT;
          end else begin
            state_d = S_FIN;
          end
        end
      end

      S_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sweep_q;
        mem_wdata_o = {1'b0, (sweep_next < pool_n) ? sweep_next : MARK};
        sweep_d     = sweep_q + AW'(1);
        if (sweep_q == AW'(MAX_BLOCKS - 1)) begin
          head_d   = '0;
          cnt_d    = pool_n;
          inited_d = 1'b1;
          state_d  = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          status_d  = ST_OK;
          granted_d = '0;
          offset_d  = '0;
          case (cmd_q)
            CMD_ALLOC: begin
              if (empty_q) begin
                status_d = ST_EMPTY;
              end else begin
                head_d      = mem_rdata_i[LW-1:0];
                cnt_d       = cnt_q - LW'(1);
                mem_we_o    = 1'b1;
                mem_waddr_o = head_q[AW-1:0];
                mem_wdata_o = {1'b1, mem_rdata_i[LW-1:0]};
                granted_d   = IDX_W'(head_q);
                offset_d    = (offset_full > FW'(OFFSET_MAX)) ? OFFSET_W'(OFFSET_MAX)
                                                              : OFFSET_W'(offset_full);
              end
            end
            CMD_FREE: begin
              if (bad_q || !mem_rdata_i[LW]) begin
                status_d = ST_BAD_FREE;
              end else begin
                head_d      = LW'(idx_q);
                cnt_d       = cnt_q + LW'(1);
                mem_we_o    = 1'b1;
                mem_waddr_o = idx_q;
                mem_wdata_o = {1'b0, head_q};
              end
            end
            default: ;
          endcase
          count_d     = COUNT_W'(cnt_d);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= MARK;
      cnt_q       <= '0;
      inited_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      inited_q    <= inited_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    bad_q     <= bad_d;
    empty_q   <= empty_d;
    sweep_q   <= sweep_d;
    prod_q    <= prod_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    offset_q  <= offset_d;
    count_q   <= count_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_index_o  = granted_q;
  assign payload_offset_o = offset_q;
  assign free_count_o     = count_q;

endmodule
`default_nettype wire
